[design/dlrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route choice package
// Shared sizes, request codes, sequencer states and bundle types.
// ----------------------------------------------------------------------------
package dlrc_pkg;

    localparam int NODE_SLOTS     = 24;
    localparam int LINKS_PER_NODE = 4;
    localparam int SEARCH_DEPTH   = 6;

    localparam int SLOT_W  = $clog2(NODE_SLOTS);
    localparam int SCAN_W  = $clog2(NODE_SLOTS + 1);
    localparam int LCNT_W  = $clog2(LINKS_PER_NODE + 1);
    localparam int LADDR_W = $clog2(NODE_SLOTS * LINKS_PER_NODE);
    localparam int LVL_W   = $clog2(SEARCH_DEPTH + 1);
    localparam int FRM_W   = (SEARCH_DEPTH > 1) ? $clog2(SEARCH_DEPTH) : 1;

    localparam int REQ_W     = 2;
    localparam int FSLOT_W   = 5;
    localparam int LSLOT_W   = 2;
    localparam int UID_W     = 31;
    localparam int LUID_W    = 32;
    localparam int DIST_W    = 8;
    localparam int PATH_W    = 12;
    localparam int CNT_W     = 5;
    localparam int PATH_MAX  = 2047;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [0:0] REG_NODE_COUNT = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_NODE  = 2'd0,
        REQ_LINK  = 2'd1,
        REQ_ROUTE = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_LINK_RD,
        S_LINK_CHK,
        S_BACK_RD,
        S_BACK_CHK,
        S_RET,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                id_we;
        logic [SLOT_W-1:0]   id_waddr;
        logic [UID_W-1:0]    id_wdata;
        logic                lk_we;
        logic [LADDR_W-1:0]  lk_waddr;
        logic [LUID_W-1:0]   nb_wdata;
        logic [DIST_W-1:0]   dist_wdata;
    } wr_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  id_raddr;
        logic [LADDR_W-1:0] lk_raddr;
    } rd_req_t;

    typedef struct packed {
        logic [UID_W-1:0]  id;
        logic [LUID_W-1:0] nb;
        logic [DIST_W-1:0] dist_val;
    } rd_data_t;

    typedef struct packed {
        logic [LUID_W-1:0]  next_uid;
        logic [LSLOT_W-1:0] next_link_index;
        logic [PATH_W-1:0]  path_dist;
        logic               route_found;
    } result_t;

endpackage
`default_nettype wire

[design/dlrc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route choice channels
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface dlrc_in_if;
    logic                          valid;
    logic                          ready;
    logic [dlrc_pkg::REQ_W-1:0]    req_type;
    logic [dlrc_pkg::FSLOT_W-1:0]  slot;
    logic [dlrc_pkg::LSLOT_W-1:0]  link_slot;
    logic [dlrc_pkg::UID_W-1:0]    node_uid;
    logic signed [dlrc_pkg::LUID_W-1:0] link_uid;
    logic [dlrc_pkg::DIST_W-1:0]   link_dist;
    logic [dlrc_pkg::UID_W-1:0]    current_uid;
    logic [dlrc_pkg::UID_W-1:0]    nearest_uid;
    logic [dlrc_pkg::UID_W-1:0]    runner_up_uid;

    modport source (output valid, req_type, slot, link_slot, node_uid, link_uid, link_dist,
                    current_uid, nearest_uid, runner_up_uid, input ready);
    modport sink (input valid, req_type, slot, link_slot, node_uid, link_uid, link_dist,
                  current_uid, nearest_uid, runner_up_uid, output ready);
endinterface

interface dlrc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [dlrc_pkg::LUID_W-1:0] next_uid;
    logic [dlrc_pkg::LSLOT_W-1:0]       next_link_index;
    logic signed [dlrc_pkg::PATH_W-1:0] path_dist;
    logic                               route_found;

    modport source (output valid, next_uid, next_link_index, path_dist, route_found,
                    input ready);
    modport sink (input valid, next_uid, next_link_index, path_dist, route_found,
                  output ready);
endinterface
`default_nettype wire

[design/dlrc_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route choice node table
// Node id memory and link memory, each with one write and one registered read.
// ----------------------------------------------------------------------------
module dlrc_table
(
    input  wire logic               clk,
    input  wire dlrc_pkg::wr_req_t  wr,
    input  wire dlrc_pkg::rd_req_t  rd,
    output dlrc_pkg::rd_data_t      rdata
);

    logic [dlrc_pkg::UID_W-1:0]  id_mem   [dlrc_pkg::NODE_SLOTS];
    logic [dlrc_pkg::LUID_W-1:0] nb_mem   [dlrc_pkg::NODE_SLOTS * dlrc_pkg::LINKS_PER_NODE];
    logic [dlrc_pkg::DIST_W-1:0] dist_mem [dlrc_pkg::NODE_SLOTS * dlrc_pkg::LINKS_PER_NODE];

    always_ff @(posedge clk)
    begin
        if (wr.id_we)
        begin
            id_mem[wr.id_waddr] <= wr.id_wdata;
        end
        if (wr.lk_we)
        begin
            nb_mem[wr.lk_waddr]   <= wr.nb_wdata;
            dist_mem[wr.lk_waddr] <= wr.dist_wdata;
        end
        rdata.id       <= id_mem[rd.id_raddr];
        rdata.nb       <= nb_mem[rd.lk_raddr];
        rdata.dist_val <= dist_mem[rd.lk_raddr];
    end

endmodule
`default_nettype wire

[design/dlrc_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route choice shared unit
// One id compare, one saturating distance add and one distance compare.
// ----------------------------------------------------------------------------
module dlrc_alu
(
    input  wire logic [dlrc_pkg::LUID_W-1:0] op_a,
    input  wire logic [dlrc_pkg::LUID_W-1:0] op_b,
    input  wire logic [dlrc_pkg::DIST_W-1:0] add_a,
    input  wire logic [dlrc_pkg::PATH_W-1:0] add_b,
    input  wire logic [dlrc_pkg::PATH_W-1:0] cmp_a,
    input  wire logic [dlrc_pkg::PATH_W-1:0] cmp_b,
    output logic                             eq,
    output logic [dlrc_pkg::PATH_W-1:0]      sum_sat,
    output logic                             lt
);

    logic [dlrc_pkg::PATH_W:0] sum;

    always_comb
    begin
        eq  = (op_a == op_b);
        sum = {{(dlrc_pkg::PATH_W + 1 - dlrc_pkg::DIST_W){1'b0}}, add_a} + {1'b0, add_b};
        if (sum > (dlrc_pkg::PATH_W + 1)'(dlrc_pkg::PATH_MAX))
        begin
            sum_sat = dlrc_pkg::PATH_W'(dlrc_pkg::PATH_MAX);
        end
        else
        begin
            sum_sat = sum[dlrc_pkg::PATH_W-1:0];
        end
        lt = (cmp_a < cmp_b);
    end

endmodule
`default_nettype wire

[design/dlrc_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route choice search sequencer
// Depth-first search over the node table with an explicit frame stack.
// ----------------------------------------------------------------------------
module dlrc_engine
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_acc,
    input  wire logic [dlrc_pkg::REQ_W-1:0]    req_type,
    input  wire logic [dlrc_pkg::UID_W-1:0]    current_uid,
    input  wire logic [dlrc_pkg::UID_W-1:0]    nearest_uid,
    input  wire logic [dlrc_pkg::UID_W-1:0]    runner_up_uid,
    input  wire logic [dlrc_pkg::CNT_W-1:0]    node_count,
    output logic                               in_ready,
    output dlrc_pkg::rd_req_t                  rd,
    input  wire dlrc_pkg::rd_data_t            rdata,
    output logic                               res_valid,
    input  wire logic                          res_take,
    output dlrc_pkg::result_t                  res
);

    localparam int SD = dlrc_pkg::SEARCH_DEPTH;

    dlrc_pkg::state_t state_reg, state_next;

    logic [dlrc_pkg::SCAN_W-1:0]  scan_reg, scan_next;
    logic [dlrc_pkg::LCNT_W-1:0]  kidx_reg, kidx_next;
    logic [dlrc_pkg::LVL_W-1:0]   level_reg, level_next;
    logic                         find_cur_reg, find_cur_next;
    logic [dlrc_pkg::UID_W-1:0]   goal_reg, goal_next;
    logic [dlrc_pkg::LUID_W-1:0]  lk_reg, lk_next;
    logic [dlrc_pkg::SLOT_W-1:0]  bd_node_reg, bd_node_next;
    logic [dlrc_pkg::UID_W-1:0]   bd_from_reg, bd_from_next;
    logic                         bd_fin_reg, bd_fin_next;
    logic [dlrc_pkg::PATH_W-1:0]  ret_val_reg, ret_val_next;
    logic                         ret_ok_reg, ret_ok_next;
    logic [dlrc_pkg::LUID_W-1:0]  lk0_reg, lk0_next;
    logic [dlrc_pkg::LUID_W-1:0]  call_lk_reg, call_lk_next;
    logic [dlrc_pkg::LUID_W-1:0]  best_lk_reg, best_lk_next;
    logic [dlrc_pkg::LSLOT_W-1:0] root_idx_reg, root_idx_next;
    dlrc_pkg::result_t            res_reg, res_next;

    logic [dlrc_pkg::SLOT_W-1:0]  node_reg [SD];
    logic [dlrc_pkg::SLOT_W-1:0]  node_next [SD];
    logic [dlrc_pkg::UID_W-1:0]   nid_reg [SD];
    logic [dlrc_pkg::UID_W-1:0]   nid_next [SD];
    logic [dlrc_pkg::LCNT_W-1:0]  lidx_reg [SD];
    logic [dlrc_pkg::LCNT_W-1:0]  lidx_next [SD];
    logic [dlrc_pkg::PATH_W-1:0]  best_reg [SD];
    logic [dlrc_pkg::PATH_W-1:0]  best_next [SD];
    logic [SD-1:0]                bval_reg, bval_next;

    logic [dlrc_pkg::FRM_W-1:0]   lvl_idx, lvl_m1, lvl_c;
    logic [dlrc_pkg::SCAN_W-1:0]  lim;
    logic [dlrc_pkg::SLOT_W-1:0]  scan_slot;
    logic                         not_found, goal_hit, deep, visited, skip;
    logic                         lidx_end, kidx_end;

    logic [dlrc_pkg::LUID_W-1:0]  op_a, op_b;
    logic                         eq, lt;
    logic [dlrc_pkg::PATH_W-1:0]  sum_sat;

    dlrc_alu u_alu
    (
        .op_a    (op_a),
        .op_b    (op_b),
        .add_a   (rdata.dist_val),
        .add_b   (best_reg[lvl_idx]),
        .cmp_a   (ret_val_reg),
        .cmp_b   (best_reg[lvl_idx]),
        .eq      (eq),
        .sum_sat (sum_sat),
        .lt      (lt)
    );

    always_comb
    begin
        lvl_idx   = level_reg[dlrc_pkg::FRM_W-1:0];
        lvl_m1    = dlrc_pkg::FRM_W'(level_reg - 1'b1);
        lvl_c     = dlrc_pkg::FRM_W'(level_reg + 1'b1);
        scan_slot = scan_reg[dlrc_pkg::SLOT_W-1:0];
        if (int'(node_count) > dlrc_pkg::NODE_SLOTS)
        begin
            lim = dlrc_pkg::SCAN_W'(dlrc_pkg::NODE_SLOTS);
        end
        else
        begin
            lim = dlrc_pkg::SCAN_W'(node_count);
        end
        not_found = (scan_reg >= lim) || lk_reg[dlrc_pkg::LUID_W-1];
        goal_hit  = (lk_reg[dlrc_pkg::UID_W-1:0] == goal_reg);
        deep      = (int'(level_reg) >= SD - 1);
        visited   = 1'b0;
        for (int k = 0; k < SD; k++)
        begin
            if ((k <= int'(level_reg)) && (node_reg[k] == scan_slot))
            begin
                visited = 1'b1;
            end
        end
        lidx_end = (lidx_reg[lvl_idx] == dlrc_pkg::LCNT_W'(dlrc_pkg::LINKS_PER_NODE));
        kidx_end = (kidx_reg == dlrc_pkg::LCNT_W'(dlrc_pkg::LINKS_PER_NODE));

        case (state_reg)
            dlrc_pkg::S_FIND_CHK:
            begin
                op_a = {1'b0, rdata.id};
                op_b = lk_reg;
            end
            dlrc_pkg::S_LINK_CHK:
            begin
                op_a = rdata.nb;
                op_b = {1'b0, nid_reg[lvl_m1]};
            end
            dlrc_pkg::S_BACK_CHK:
            begin
                op_a = rdata.nb;
                op_b = {1'b0, bd_from_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        skip = (&rdata.nb) || ((level_reg != '0) && eq);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dlrc_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (req_type == dlrc_pkg::REQ_ROUTE) ? dlrc_pkg::S_FIND_RD
                                                                   : dlrc_pkg::S_DONE;
                end
            end
            dlrc_pkg::S_FIND_RD:
            begin
                if (not_found)
                begin
                    state_next = find_cur_reg ? dlrc_pkg::S_DONE : dlrc_pkg::S_RET;
                end
                else
                begin
                    state_next = dlrc_pkg::S_FIND_CHK;
                end
            end
            dlrc_pkg::S_FIND_CHK:
            begin
                if (!eq)
                begin
                    state_next = dlrc_pkg::S_FIND_RD;
                end
                else if (find_cur_reg)
                begin
                    state_next = dlrc_pkg::S_LINK_RD;
                end
                else if (goal_hit)
                begin
                    state_next = dlrc_pkg::S_BACK_RD;
                end
                else if (deep || visited)
                begin
                    state_next = dlrc_pkg::S_RET;
                end
                else
                begin
                    state_next = dlrc_pkg::S_LINK_RD;
                end
            end
            dlrc_pkg::S_LINK_RD:
            begin
                if (!lidx_end)
                begin
                    state_next = dlrc_pkg::S_LINK_CHK;
                end
                else if (level_reg == '0)
                begin
                    state_next = dlrc_pkg::S_DONE;
                end
                else if (!bval_reg[lvl_idx])
                begin
                    state_next = dlrc_pkg::S_RET;
                end
                else
                begin
                    state_next = dlrc_pkg::S_BACK_RD;
                end
            end
            dlrc_pkg::S_LINK_CHK:
            begin
                state_next = skip ? dlrc_pkg::S_LINK_RD : dlrc_pkg::S_FIND_RD;
            end
            dlrc_pkg::S_BACK_RD:
            begin
                state_next = kidx_end ? dlrc_pkg::S_RET : dlrc_pkg::S_BACK_CHK;
            end
            dlrc_pkg::S_BACK_CHK:
            begin
                state_next = eq ? dlrc_pkg::S_RET : dlrc_pkg::S_BACK_RD;
            end
            dlrc_pkg::S_RET:
            begin
                state_next = dlrc_pkg::S_LINK_RD;
            end
            dlrc_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = dlrc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dlrc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        scan_next     = scan_reg;
        kidx_next     = kidx_reg;
        level_next    = level_reg;
        find_cur_next = find_cur_reg;
        goal_next     = goal_reg;
        lk_next       = lk_reg;
        bd_node_next  = bd_node_reg;
        bd_from_next  = bd_from_reg;
        bd_fin_next   = bd_fin_reg;
        ret_val_next  = ret_val_reg;
        ret_ok_next   = ret_ok_reg;
        lk0_next      = lk0_reg;
        call_lk_next  = call_lk_reg;
        best_lk_next  = best_lk_reg;
        root_idx_next = root_idx_reg;
        res_next      = res_reg;
        bval_next     = bval_reg;
        for (int k = 0; k < SD; k++)
        begin
            node_next[k] = node_reg[k];
            nid_next[k]  = nid_reg[k];
            lidx_next[k] = lidx_reg[k];
            best_next[k] = best_reg[k];
        end

        in_ready    = (state_reg == dlrc_pkg::S_IDLE);
        res_valid   = (state_reg == dlrc_pkg::S_DONE);
        res         = res_reg;
        rd.id_raddr = scan_slot;
        if (state_reg == dlrc_pkg::S_BACK_RD)
        begin
            rd.lk_raddr = dlrc_pkg::LADDR_W'(bd_node_reg)
                        * dlrc_pkg::LADDR_W'(dlrc_pkg::LINKS_PER_NODE)
                        + dlrc_pkg::LADDR_W'(kidx_reg);
        end
        else
        begin
            rd.lk_raddr = dlrc_pkg::LADDR_W'(node_reg[lvl_idx])
                        * dlrc_pkg::LADDR_W'(dlrc_pkg::LINKS_PER_NODE)
                        + dlrc_pkg::LADDR_W'(lidx_reg[lvl_idx]);
        end

        case (state_reg)
            dlrc_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    goal_next     = (current_uid == nearest_uid) ? runner_up_uid : nearest_uid;
                    lk_next       = {1'b0, current_uid};
                    scan_next     = '0;
                    find_cur_next = 1'b1;
                    res_next      = '0;
                end
            end
            dlrc_pkg::S_FIND_RD:
            begin
                if (not_found)
                begin
                    if (find_cur_reg)
                    begin
                        res_next.next_uid        = '1;
                        res_next.next_link_index = '0;
                        res_next.path_dist       = '1;
                        res_next.route_found     = 1'b0;
                    end
                    else
                    begin
                        ret_ok_next = 1'b0;
                    end
                end
            end
            dlrc_pkg::S_FIND_CHK:
            begin
                if (!eq)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                else if (find_cur_reg)
                begin
                    node_next[0]  = scan_slot;
                    nid_next[0]   = lk_reg[dlrc_pkg::UID_W-1:0];
                    lidx_next[0]  = '0;
                    bval_next[0]  = 1'b0;
                    level_next    = '0;
                    find_cur_next = 1'b0;
                end
                else if (goal_hit)
                begin
                    bd_node_next = scan_slot;
                    bd_from_next = nid_reg[lvl_idx];
                    bd_fin_next  = 1'b0;
                    kidx_next    = '0;
                end
                else if (deep || visited)
                begin
                    ret_ok_next = 1'b0;
                end
                else
                begin
                    node_next[lvl_c] = scan_slot;
                    nid_next[lvl_c]  = lk_reg[dlrc_pkg::UID_W-1:0];
                    lidx_next[lvl_c] = '0;
                    bval_next[lvl_c] = 1'b0;
                    level_next       = level_reg + 1'b1;
                end
            end
            dlrc_pkg::S_LINK_RD:
            begin
                if (lidx_end)
                begin
                    if (level_reg == '0)
                    begin
                        res_next.next_uid        = bval_reg[0] ? best_lk_reg : lk0_reg;
                        res_next.next_link_index = bval_reg[0] ? root_idx_reg : '0;
                        res_next.path_dist       = bval_reg[0] ? best_reg[0] : '1;
                        res_next.route_found     = bval_reg[0];
                    end
                    else if (!bval_reg[lvl_idx])
                    begin
                        level_next  = level_reg - 1'b1;
                        ret_ok_next = 1'b0;
                    end
                    else
                    begin
                        bd_node_next = node_reg[lvl_idx];
                        bd_from_next = nid_reg[lvl_m1];
                        bd_fin_next  = 1'b1;
                        kidx_next    = '0;
                    end
                end
            end
            dlrc_pkg::S_LINK_CHK:
            begin
                if ((level_reg == '0) && (lidx_reg[0] == '0))
                begin
                    lk0_next = rdata.nb;
                end
                if (skip)
                begin
                    lidx_next[lvl_idx] = lidx_reg[lvl_idx] + 1'b1;
                end
                else
                begin
                    lk_next   = rdata.nb;
                    scan_next = '0;
                    if (level_reg == '0)
                    begin
                        call_lk_next = rdata.nb;
                    end
                end
            end
            dlrc_pkg::S_BACK_RD:
            begin
                if (kidx_end)
                begin
                    ret_ok_next = 1'b0;
                    if (bd_fin_reg)
                    begin
                        level_next = level_reg - 1'b1;
                    end
                end
            end
            dlrc_pkg::S_BACK_CHK:
            begin
                if (eq)
                begin
                    ret_ok_next = 1'b1;
                    if (bd_fin_reg)
                    begin
                        ret_val_next = sum_sat;
                        level_next   = level_reg - 1'b1;
                    end
                    else
                    begin
                        ret_val_next = {{(dlrc_pkg::PATH_W - dlrc_pkg::DIST_W){1'b0}},
                                        rdata.dist_val};
                    end
                end
                else
                begin
                    kidx_next = kidx_reg + 1'b1;
                end
            end
            dlrc_pkg::S_RET:
            begin
                if (ret_ok_reg && (!bval_reg[lvl_idx] || lt))
                begin
                    best_next[lvl_idx] = ret_val_reg;
                    bval_next[lvl_idx] = 1'b1;
                    if (level_reg == '0)
                    begin
                        root_idx_next = lidx_reg[0][dlrc_pkg::LSLOT_W-1:0];
                        best_lk_next  = call_lk_reg;
                    end
                end
                lidx_next[lvl_idx] = lidx_reg[lvl_idx] + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dlrc_pkg::S_IDLE;
            scan_reg     <= '0;
            kidx_reg     <= '0;
            level_reg    <= '0;
            find_cur_reg <= 1'b0;
            ret_ok_reg   <= 1'b0;
            bval_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            kidx_reg     <= kidx_next;
            level_reg    <= level_next;
            find_cur_reg <= find_cur_next;
            ret_ok_reg   <= ret_ok_next;
            bval_reg     <= bval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        goal_reg     <= goal_next;
        lk_reg       <= lk_next;
        bd_node_reg  <= bd_node_next;
        bd_from_reg  <= bd_from_next;
        bd_fin_reg   <= bd_fin_next;
        ret_val_reg  <= ret_val_next;
        lk0_reg      <= lk0_next;
        call_lk_reg  <= call_lk_next;
        best_lk_reg  <= best_lk_next;
        root_idx_reg <= root_idx_next;
        res_reg      <= res_next;
        for (int k = 0; k < SD; k++)
        begin
            node_reg[k] <= node_next[k];
            nid_reg[k]  <= nid_next[k];
            lidx_reg[k] <= lidx_next[k];
            best_reg[k] <= best_next[k];
        end
    end

endmodule
`default_nettype wire

[design/depth_limited_route_choice_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-limited route choice
// Node table, search sequencer, configuration register and result register.
// ----------------------------------------------------------------------------
// A route query runs a depth-first search on one sequencer that shares a single
// dlrc_alu (one id compare, one saturating add, one distance compare) across its
// states; the cost of each examined link is set by the word-by-word scans of the
// node id memory and the link memory, so a query's run time grows with the
// number of links walked.
// The block takes a new transaction while a finished result waits at the output.
module depth_limited_route_choice_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dlrc_in_if.sink                            in_ch,
    dlrc_out_if.source                         out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dlrc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dlrc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dlrc_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    logic [dlrc_pkg::CNT_W-1:0] node_count_reg, node_count_next;
    logic                       out_valid_reg, out_valid_next;
    dlrc_pkg::result_t          out_reg;

    logic               in_acc, eng_ready, res_valid, out_load;
    dlrc_pkg::result_t  res;
    dlrc_pkg::wr_req_t  wr;
    dlrc_pkg::rd_req_t  rd;
    dlrc_pkg::rd_data_t rdata;

    always_comb
    begin
        pready          = 1'b1;
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && (paddr[2] == dlrc_pkg::REG_NODE_COUNT))
        begin
            node_count_next = pwdata[dlrc_pkg::CNT_W-1:0];
        end
        if (paddr[2] == dlrc_pkg::REG_NODE_COUNT)
        begin
            prdata = {{(dlrc_pkg::PDATA_W - dlrc_pkg::CNT_W){1'b0}}, node_count_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign in_ch.ready = eng_ready;
    assign in_acc      = in_ch.valid && eng_ready;

    always_comb
    begin
        wr.id_we      = in_acc && (in_ch.req_type == dlrc_pkg::REQ_NODE)
                        && (int'(in_ch.slot) < dlrc_pkg::NODE_SLOTS);
        wr.id_waddr   = in_ch.slot[dlrc_pkg::SLOT_W-1:0];
        wr.id_wdata   = in_ch.node_uid;
        wr.lk_we      = in_acc && (in_ch.req_type == dlrc_pkg::REQ_LINK)
                        && (int'(in_ch.slot) < dlrc_pkg::NODE_SLOTS)
                        && (int'(in_ch.link_slot) < dlrc_pkg::LINKS_PER_NODE);
        wr.lk_waddr   = dlrc_pkg::LADDR_W'(in_ch.slot)
                      * dlrc_pkg::LADDR_W'(dlrc_pkg::LINKS_PER_NODE)
                      + dlrc_pkg::LADDR_W'(in_ch.link_slot);
        wr.nb_wdata   = in_ch.link_uid;
        wr.dist_wdata = in_ch.link_dist;
    end

    dlrc_table u_table
    (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    dlrc_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_acc        (in_acc),
        .req_type      (in_ch.req_type),
        .current_uid   (in_ch.current_uid),
        .nearest_uid   (in_ch.nearest_uid),
        .runner_up_uid (in_ch.runner_up_uid),
        .node_count    (node_count_reg),
        .in_ready      (eng_ready),
        .rd            (rd),
        .rdata         (rdata),
        .res_valid     (res_valid),
        .res_take      (out_load),
        .res           (res)
    );

    always_comb
    begin
        out_load       = res_valid && (!out_valid_reg || out_ch.ready);
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.next_uid        = out_reg.next_uid;
    assign out_ch.next_link_index = out_reg.next_link_index;
    assign out_ch.path_dist       = out_reg.path_dist;
    assign out_ch.route_found     = out_reg.route_found;

endmodule
`default_nettype wire
